### sv/lmfs_pkg.sv
package lmfs_pkg;

	localparam logic [3:0] MARK_LEN = 4'd9;

	localparam logic KIND_NAME   = 1'b0;
	localparam logic KIND_RECORD = 1'b1;

	localparam logic [7:0] NEWLINE = 8'h0A;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  file_index;
		logic [7:0]  name_char;
		logic [5:0]  name_length;
		logic        default_named;
		logic [15:0] content_start;
		logic [15:0] content_length;
		logic        run_end;
	} out_item_t;

	// Results caused by one accepted byte; r1 is used only when two is set.
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} bundle_t;

	// Marker text "// file: ", one byte per match position.
	function automatic logic [7:0] marker_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = 8'h2F;
			4'd1:    b = 8'h2F;
			4'd2:    b = 8'h20;
			4'd3:    b = 8'h66;
			4'd4:    b = 8'h69;
			4'd5:    b = 8'h6C;
			4'd6:    b = 8'h65;
			4'd7:    b = 8'h3A;
			4'd8:    b = 8'h20;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### sv/lmfs_front.sv
module lmfs_front #(
	parameter int MAX_FILES = 8,
	parameter int NAME_CAP  = 63,
	parameter int POS_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  lmfs_pkg::in_item_t item,
	output logic               bnd_push,
	output lmfs_pkg::bundle_t  bnd
);

	localparam int FF_W = $clog2(MAX_FILES + 1);
	localparam int NC_W = $clog2(NAME_CAP + 1);
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [POS_BITS-1:0] pos_q, ocs_q;
	logic                ls_q, name_q;
	logic [3:0]          mp_q;
	logic [NC_W-1:0]     nc_q;
	logic [FF_W-1:0]     ff_q;

	logic [POS_BITS-1:0] pos_next, mark_start, ocs_n, fin_start;
	logic                ls_n, name_n;
	logic [3:0]          mp_n, mp_try;
	logic [NC_W-1:0]     nc_n;
	logic [FF_W-1:0]     ff_n;
	logic                va, fin;
	lmfs_pkg::out_item_t res_a, res_f;

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic logic [2:0] idx_of(input logic [FF_W-1:0] f);
		logic [31:0] w;
		w = 32'(f) - 32'd1;
		return w[2:0];
	endfunction

	function automatic logic [5:0] len_of(input logic [NC_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[5:0];
	endfunction

	assign fin        = item.final_byte;
	assign pos_next   = (pos_q == POS_MAX) ? pos_q : pos_q + POS_BITS'(1);
	assign mark_start = (pos_q >= POS_BITS'(8)) ? pos_q - POS_BITS'(8) : '0;
	assign mp_try     = (mp_q < lmfs_pkg::MARK_LEN &&
		item.text_byte == lmfs_pkg::marker_byte(mp_q)) ? mp_q + 4'd1 : 4'd0;

	always_comb begin
		ls_n   = ls_q;
		name_n = name_q;
		mp_n   = mp_q;
		nc_n   = nc_q;
		ff_n   = ff_q;
		ocs_n  = ocs_q;
		va     = 1'b0;
		res_a  = '0;
		if (name_q) begin
			if (item.text_byte == lmfs_pkg::NEWLINE) begin
				name_n = 1'b0;
				ocs_n  = pos_next;
				ls_n   = 1'b1;
			end else begin
				if (nc_q < NC_W'(NAME_CAP)) begin
					va               = 1'b1;
					res_a.kind       = lmfs_pkg::KIND_NAME;
					res_a.file_index = idx_of(ff_q);
					res_a.name_char  = item.text_byte;
					nc_n             = nc_q + NC_W'(1);
				end
				ls_n = 1'b0;
			end
		end else begin
			if (ff_q < FF_W'(MAX_FILES) && (ls_q || mp_q != 4'd0)) begin
				mp_n = mp_try;
				if (mp_try == lmfs_pkg::MARK_LEN) begin
					mp_n = 4'd0;
					if (ff_q != '0) begin
						va                   = 1'b1;
						res_a.kind           = lmfs_pkg::KIND_RECORD;
						res_a.file_index     = idx_of(ff_q);
						res_a.name_length    = len_of(nc_q);
						res_a.content_start  = to16(ocs_q);
						res_a.content_length = (mark_start >= ocs_q) ?
							to16(mark_start - ocs_q) : 16'd0;
					end
					ff_n   = ff_q + FF_W'(1);
					name_n = 1'b1;
					nc_n   = '0;
					ocs_n  = pos_next;
				end
			end else begin
				mp_n = 4'd0;
			end
			ls_n = (item.text_byte == lmfs_pkg::NEWLINE);
		end
		res_a.run_end = !fin;
	end

	// End-of-text record, built from the state this byte leaves behind.
	assign fin_start = name_n ? pos_next : ocs_n;

	always_comb begin
		res_f         = '0;
		res_f.kind    = lmfs_pkg::KIND_RECORD;
		res_f.run_end = 1'b1;
		if (ff_n == '0) begin
			res_f.default_named  = 1'b1;
			res_f.content_length = to16(pos_next);
		end else begin
			res_f.file_index     = idx_of(ff_n);
			res_f.name_length    = len_of(nc_n);
			res_f.content_start  = to16(fin_start);
			res_f.content_length = (pos_next >= fin_start) ?
				to16(pos_next - fin_start) : 16'd0;
		end
	end

	assign bnd_push = take && (va || fin);
	assign bnd.two  = va && fin;
	assign bnd.r0   = va ? res_a : res_f;
	assign bnd.r1   = res_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ls_q   <= 1'b1;
			mp_q   <= 4'd0;
			name_q <= 1'b0;
			nc_q   <= '0;
			ff_q   <= '0;
			ocs_q  <= '0;
		end else if (take) begin
			if (fin) begin
				pos_q  <= '0;
				ls_q   <= 1'b1;
				mp_q   <= 4'd0;
				name_q <= 1'b0;
				nc_q   <= '0;
				ff_q   <= '0;
				ocs_q  <= '0;
			end else begin
				pos_q  <= pos_next;
				ls_q   <= ls_n;
				mp_q   <= mp_n;
				name_q <= name_n;
				nc_q   <= nc_n;
				ff_q   <= ff_n;
				ocs_q  <= ocs_n;
			end
		end
	end

	a_name_has_file: assert property (@(posedge clk) disable iff (!arst_n)
		name_q |-> ff_q != '0)
		else $error("name bytes with no open file");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && fin |=> pos_q == '0 && ff_q == '0 && !name_q)
		else $error("state not cleared after end of text");

endmodule

### sv/lmfs_fifo.sv
module lmfs_fifo #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  lmfs_pkg::bundle_t wr_data,
	input  logic              rd_en,
	output lmfs_pkg::bundle_t rd_data,
	output logic              full,
	output logic              empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lmfs_pkg::bundle_t mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (rd_en) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full) && !(rd_en && empty))
		else $error("queue written when full or read when empty");

endmodule

### sv/lmfs_back.sv
module lmfs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lmfs_pkg::bundle_t   q_data,
	input  logic                q_empty,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output lmfs_pkg::out_item_t result
);

	lmfs_pkg::bundle_t bnd_q;
	logic              valid_q, sel_q;
	logic              load;

	// Load the next bundle when the held one has nothing left to hand out.
	assign load   = !q_empty && (!valid_q || (pop && (sel_q || !bnd_q.two)));
	assign q_pop  = load;
	assign empty  = !valid_q;
	assign result = sel_q ? bnd_q.r1 : bnd_q.r0;

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (valid_q && pop) begin
			if (!sel_q && bnd_q.two) begin
				sel_q <= 1'b1;
			end else begin
				valid_q <= 1'b0;
				sel_q   <= 1'b0;
			end
		end
	end

	a_second_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> valid_q && bnd_q.two)
		else $error("second result selected without a pair");

endmodule

### sv/line_marker_file_splitter.sv
// Channel   Handshake          Payload                 Moves per transaction
// input     push / full        item   (in_item_t)      one text byte
// output    pop / empty        result (out_item_t)     one name byte or file record
//
// Takes one byte every cycle while full is low; the parser updates its state in
// the cycle the transaction lands. A byte that causes results writes one queue
// entry holding one or two results; the output stage hands out one per cycle
// while pop is high, so a final byte that also yields a name byte or record
// takes two pops. Results reach the ports via the queue and the output register.
// Reset clears the parser state,
// the queue pointers and the output valid flag; no clearing pass.
module line_marker_file_splitter #(
	parameter int MAX_FILES   = 8,
	parameter int NAME_CAP    = 63,
	parameter int POS_BITS    = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lmfs_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output lmfs_pkg::out_item_t result
);

	logic              take;
	logic              bnd_push;
	lmfs_pkg::bundle_t bnd;
	lmfs_pkg::bundle_t q_data;
	logic              q_empty, q_pop;

	// Accept a transaction only while the queue has room for its results.
	assign take = push && !full;

	// Front: match the marker, track names and offsets, build records.
	lmfs_front #(
		.MAX_FILES (MAX_FILES),
		.NAME_CAP  (NAME_CAP),
		.POS_BITS  (POS_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.bnd_push (bnd_push),
		.bnd      (bnd)
	);

	// Queue: hold per-byte result groups so the two sides stall apart.
	lmfs_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bnd_push),
		.wr_data (bnd),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	// Back: drain each group one result per transaction.
	lmfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

### tb/sv/split_checker.sv
module split_checker #(
	parameter int FILE_LIMIT = 8,
	parameter int NAME_LIMIT = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  lmfs_pkg::in_item_t  item,
	input  logic                empty,
	input  logic                pop,
	input  lmfs_pkg::out_item_t result,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lmfs_pkg::*;

	localparam logic [71:0] MARKER_TEXT = "// file: ";
	localparam logic [15:0] POS_TOP     = 16'hFFFF;

	// Scanner state, mirrored from the block
	logic [15:0] pos_q;
	logic        at_line_start;
	logic [3:0]  marker_hits;
	logic        naming;
	logic [5:0]  name_len;
	logic [3:0]  files_seen;
	logic [15:0] body_start;

	out_item_t awaited_results[$];

	function automatic out_item_t make_result(input logic kind, input logic [2:0] idx,
			input logic [7:0] ch, input logic [5:0] nlen, input logic dflt,
			input logic [15:0] start, input logic [15:0] len);
		out_item_t r;
		r.kind           = kind;
		r.file_index     = idx;
		r.name_char      = ch;
		r.name_length    = nlen;
		r.default_named  = dflt;
		r.content_start  = start;
		r.content_length = len;
		r.run_end        = 1'b0;
		return r;
	endfunction

	task automatic restart_scan();
		pos_q         = '0;
		at_line_start = 1'b1;
		marker_hits   = '0;
		naming        = 1'b0;
		name_len      = '0;
		files_seen    = '0;
		body_start    = '0;
	endtask

	// Advance the scanner by one text byte and queue the results it causes.
	task automatic scan_text_byte(input in_item_t it);
		logic [15:0] nxt, mark_at, start, len;
		logic [3:0]  cur_file;
		out_item_t   made[2];
		out_item_t   r;
		int          n, k;
		n        = 0;
		nxt      = (pos_q == POS_TOP) ? pos_q : pos_q + 16'd1;
		cur_file = files_seen - 4'd1;
		if (naming) begin
			if (it.text_byte == NEWLINE) begin
				naming        = 1'b0;
				body_start    = nxt;
				at_line_start = 1'b1;
			end else begin
				if (int'(name_len) < NAME_LIMIT) begin
					made[n] = make_result(KIND_NAME, cur_file[2:0], it.text_byte, '0, 1'b0,
						'0, '0);
					n++;
					name_len++;
				end
				at_line_start = 1'b0;
			end
		end else begin
			if (int'(files_seen) < FILE_LIMIT && (at_line_start || marker_hits != 0)) begin
				k = int'(marker_hits);
				if (marker_hits < MARK_LEN && it.text_byte == MARKER_TEXT[8*(8-k) +: 8])
					marker_hits++;
				else
					marker_hits = '0;
				if (marker_hits == MARK_LEN) begin
					mark_at     = (pos_q >= 16'd8) ? pos_q - 16'd8 : '0;
					marker_hits = '0;
					if (files_seen != 0) begin
						len = (mark_at >= body_start) ? mark_at - body_start : '0;
						made[n] = make_result(KIND_RECORD, cur_file[2:0], '0, name_len, 1'b0,
							body_start, len);
						n++;
					end
					files_seen++;
					naming     = 1'b1;
					name_len   = '0;
					body_start = nxt;
				end
			end else begin
				marker_hits = '0;
			end
			at_line_start = (it.text_byte == NEWLINE);
		end
		pos_q = nxt;

		if (it.final_byte) begin
			if (files_seen == 0) begin
				made[n] = make_result(KIND_RECORD, '0, '0, '0, 1'b1, '0, nxt);
			end else begin
				cur_file = files_seen - 4'd1;
				start    = naming ? nxt : body_start;
				len      = (nxt >= start) ? nxt - start : '0;
				made[n]  = make_result(KIND_RECORD, cur_file[2:0], '0, name_len, 1'b0,
					start, len);
			end
			n++;
			restart_scan();
		end

		for (int i = 0; i < n; i++) begin
			r         = made[i];
			r.run_end = (i == n - 1);
			awaited_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			restart_scan();
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (push && !full)
				scan_text_byte(item);
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: kind %0d file %0d char %h len %0d",
							result.kind, result.file_index, result.name_char,
							result.name_length);
				end else begin
					want = awaited_results.pop_front();
					if (result.kind !== want.kind || result.file_index !== want.file_index ||
							result.name_char !== want.name_char ||
							result.name_length !== want.name_length ||
							result.default_named !== want.default_named ||
							result.content_start !== want.content_start ||
							result.content_length !== want.content_length ||
							result.run_end !== want.run_end) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch expected: kind %0d file %0d char %h nlen %0d dflt %0d start %0d clen %0d end %0d",
								want.kind, want.file_index, want.name_char, want.name_length,
								want.default_named, want.content_start, want.content_length,
								want.run_end);
							$display("mismatch actual:   kind %0d file %0d char %h nlen %0d dflt %0d start %0d clen %0d end %0d",
								result.kind, result.file_index, result.name_char,
								result.name_length, result.default_named, result.content_start,
								result.content_length, result.run_end);
						end
					end
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

### tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lmfs_pkg::*;

	localparam int PERIOD        = 4;
	localparam int RANDOM_ITEMS  = 1550;
	// Longest stretch without any transaction: the receiver hold-off plus margin.
	localparam int QUIET_LIMIT   = 3000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	int        fail_count;
	int        pending;
	int        items_sent;
	logic      calm;        // suppress idling on both sides while set
	logic [7:0] text_q[$];  // text under construction, sent as one unit

	always #(PERIOD/2) clk = ~clk;

	line_marker_file_splitter i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	split_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Offer one byte; called and returning at a falling edge. Push is touched at
	// most once per edge, so a back-to-back transaction keeps it high.
	task automatic send_byte(input logic [7:0] b, input logic last);
		calm = (items_sent >= 700 && items_sent < 1000);
		while (!calm && $urandom_range(99) < 34) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{text_byte: b, final_byte: last};
		// hold until the transaction lands
		do @(posedge clk); while (full);
		items_sent++;
		@(negedge clk);
	endtask

	// Send the collected text, flagging its last byte, and clear it.
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic add_marker();
		for (int i = 0; i < MARK_LEN; i++)
			text_q.push_back(marker_byte(4'(i)));
	endtask

	// Mostly printable text; now and then any byte value at all.
	function automatic logic [7:0] text_char();
		if ($urandom_range(99) < 20)
			return 8'($urandom_range(255));
		return 8'($urandom_range(126, 32));
	endfunction

	// Build one random text: lines of content, well-formed markers with names,
	// and broken markers. Some texts carry more markers than the block accepts.
	task automatic build_random_text();
		int lines, mark_pct, sel, len, k;
		logic [7:0] mark[9];
		lines    = $urandom_range(6, 1);
		mark_pct = 45;
		if ($urandom_range(7) == 0) begin
			lines    = $urandom_range(12, 10);
			mark_pct = 90;
		end
		for (int l = 0; l < lines; l++) begin
			sel = $urandom_range(99);
			if (sel < mark_pct) begin
				add_marker();
				len = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
				repeat (len) text_q.push_back(text_char());
			end else if (sel < mark_pct + 10) begin
				// break the marker: wrong byte somewhere, or not at a line start
				for (int i = 0; i < MARK_LEN; i++)
					mark[i] = marker_byte(4'(i));
				if ($urandom_range(1)) begin
					k       = $urandom_range(MARK_LEN - 1);
					mark[k] = 8'($urandom_range(255));
				end else begin
					text_q.push_back(8'($urandom_range(126, 32)));
				end
				for (int i = 0; i < MARK_LEN; i++)
					text_q.push_back(mark[i]);
				repeat ($urandom_range(4)) text_q.push_back(text_char());
			end else begin
				repeat ($urandom_range(12)) text_q.push_back(text_char());
			end
			// drop the newline sometimes, only ever on the last line
			if (l < lines - 1 || $urandom_range(99) < 70)
				text_q.push_back(NEWLINE);
		end
		if (text_q.size() == 0)
			text_q.push_back(text_char());
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		item       = '0;
		calm       = 1'b0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Text without a marker: one default-named record over both bytes.
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		send_text();

		// Marker completing on the last byte: the open file's record comes
		// first, then an empty record for the new file.
		add_marker();
		add_str("a\n");
		add_marker();
		send_text();

		// Random texts, mostly well-formed.
		while (items_sent < RANDOM_ITEMS) begin
			build_random_text();
			send_text();
		end

		push <= 1'b0;
		// drain: wait for every awaited result, then let stragglers show up
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: pop at random, once hold off long enough to fill the block
	// and push back on the sender.
	initial begin : receiver
		int cycles, hold;
		pop    = 1'b0;
		cycles = 0;
		hold   = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycles++;
			if (cycles == 600)
				hold = 400;
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= calm || ($urandom_range(99) >= 34);
			end
		end
	end

	// Watchdog: end the run when no transaction lands on either side for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((push && !full) || (pop && !empty)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
